// ===== design/sstq_pkg.sv =====
// Shared constants, codes and types of the sorted sleep timer queue.
`default_nettype none

package sstq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int MAX_RESULTS = 8;

   localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int IDX_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);

   localparam int CMD_W    = 2;
   localparam int TASK_W   = 3;
   localparam int TICKS_W  = 16;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_WOKEN    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [TASK_W-1:0]  task_id;
      logic [TICKS_W-1:0] sleep_ticks;
      logic [TIME_W-1:0]  now_time;
   } req_item_type;

   typedef struct packed {
      logic [TASK_W-1:0]  tid;
      logic [TICKS_W-1:0] remaining;
      logic [TIME_W-1:0]  stamp;
   } entry_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_LOAD,
      DP_INSERT,
      DP_DROP,
      DP_AGE
   } dp_op_type;

   typedef struct packed {
      dp_op_type             op;
      logic [IDX_W-1:0]      idx;
      logic                  res_load;
      logic [STATUS_W-1:0]   res_status;
      logic                  res_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] count;
      logic             rem_lt;
      logic             task_match;
      logic             head_zero;
      logic             next_zero;
      logic             out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/sstq_if.sv =====
// Request and response channel interfaces of the sorted sleep timer queue.
`default_nettype none

interface sstq_req_if;
   logic                          valid;
   logic                          ready;
   logic [sstq_pkg::CMD_W-1:0]    command;
   logic [sstq_pkg::TASK_W-1:0]   task_id;
   logic [sstq_pkg::TICKS_W-1:0]  sleep_ticks;
   logic [sstq_pkg::TIME_W-1:0]   now_time;

   modport source (output valid, command, task_id, sleep_ticks, now_time, input ready);
   modport sink   (input valid, command, task_id, sleep_ticks, now_time, output ready);
endinterface

interface sstq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sstq_pkg::STATUS_W-1:0] status;
   logic [sstq_pkg::TASK_W-1:0]   woken_task;
   logic                          last_result;

   modport source (output valid, status, woken_task, last_result, input ready);
   modport sink   (input valid, status, woken_task, last_result, output ready);
endinterface

`default_nettype wire

// ===== design/sstq_datapath.sv =====
// Datapath of the sorted sleep timer queue: entries, item latch and result register.
`default_nettype none

module sstq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sstq_pkg::req_item_type        req_item,
   input  wire sstq_pkg::ctrl_cmd_type        ctl,
   output sstq_pkg::dp_status_type            stat,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [sstq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [sstq_pkg::TASK_W-1:0]        rsp_woken_task,
   output logic                               rsp_last_result
);

   sstq_pkg::entry_type                    entry_ff [sstq_pkg::QUEUE_DEPTH];
   sstq_pkg::entry_type                    entry_in [sstq_pkg::QUEUE_DEPTH];
   logic [sstq_pkg::IDX_W-1:0]             count_ff, count_in;
   sstq_pkg::req_item_type                 item_ff, item_in;
   logic                                   out_valid_ff, out_valid_in;
   logic [sstq_pkg::STATUS_W-1:0]          out_status_ff, out_status_in;
   logic [sstq_pkg::TASK_W-1:0]            out_task_ff, out_task_in;
   logic                                   out_last_ff, out_last_in;
   logic [sstq_pkg::ADDR_W-1:0]            addr;
   logic [sstq_pkg::TIME_W-1:0]            elapsed;

   assign addr    = ctl.idx[sstq_pkg::ADDR_W-1:0];
   assign elapsed = item_ff.now_time - entry_ff[addr].stamp;

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      item_in  = item_ff;
      case (ctl.op)
         sstq_pkg::DP_LOAD: begin
            item_in = req_item;
         end
         sstq_pkg::DP_INSERT: begin
            for (int j = 1; j < sstq_pkg::QUEUE_DEPTH; j++) begin
               if (sstq_pkg::IDX_W'(j) > ctl.idx) begin
                  entry_in[j] = entry_ff[j-1];
               end
            end
            entry_in[addr].tid       = item_ff.task_id;
            entry_in[addr].remaining = item_ff.sleep_ticks;
            entry_in[addr].stamp     = item_ff.now_time;
            count_in = count_ff + 1'b1;
         end
         sstq_pkg::DP_DROP: begin
            for (int j = 0; j < sstq_pkg::QUEUE_DEPTH - 1; j++) begin
               if (sstq_pkg::IDX_W'(j) >= ctl.idx) begin
                  entry_in[j] = entry_ff[j+1];
               end
            end
            count_in = count_ff - 1'b1;
         end
         sstq_pkg::DP_AGE: begin
            if (elapsed >= {{(sstq_pkg::TIME_W-sstq_pkg::TICKS_W){1'b0}},
                            entry_ff[addr].remaining}) begin
               entry_in[addr].remaining = '0;
            end else begin
               entry_in[addr].remaining = entry_ff[addr].remaining
                                          - elapsed[sstq_pkg::TICKS_W-1:0];
            end
            entry_in[addr].stamp = item_ff.now_time;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_task_in   = out_task_ff;
      out_last_in   = out_last_ff;
      if (ctl.res_load) begin
         out_valid_in  = 1'b1;
         out_status_in = ctl.res_status;
         out_task_in   = (ctl.res_status == sstq_pkg::ST_WOKEN) ? entry_ff[0].tid : '0;
         out_last_in   = ctl.res_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      item_ff       <= item_in;
      out_status_ff <= out_status_in;
      out_task_ff   <= out_task_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      stat.command    = item_ff.command;
      stat.count      = count_ff;
      stat.rem_lt     = entry_ff[addr].remaining < item_ff.sleep_ticks;
      stat.task_match = entry_ff[addr].tid == item_ff.task_id;
      stat.head_zero  = entry_ff[0].remaining == '0;
      stat.next_zero  = entry_ff[1].remaining == '0;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_woken_task  = out_task_ff;
   assign rsp_last_result = out_last_ff;

endmodule

`default_nettype wire

// ===== design/sstq_controller.sv =====
// Controller state machine of the sorted sleep timer queue.
`default_nettype none

module sstq_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire sstq_pkg::dp_status_type stat,
   output sstq_pkg::ctrl_cmd_type      ctl
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_ADD_SCAN = 6'b000100,
      S_REM_SCAN = 6'b001000,
      S_AGE      = 6'b010000,
      S_POP      = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [sstq_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [sstq_pkg::NRES_W-1:0]   n_ff, n_in;
   logic                          more;

   assign more = (n_ff < sstq_pkg::NRES_W'(sstq_pkg::MAX_RESULTS - 1))
                 && (stat.count > sstq_pkg::IDX_W'(1)) && stat.next_zero;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      n_in           = n_ff;
      req_ready      = 1'b0;
      ctl.op         = sstq_pkg::DP_NONE;
      ctl.idx        = idx_ff;
      ctl.res_load   = 1'b0;
      ctl.res_status = sstq_pkg::ST_DONE;
      ctl.res_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op   = sstq_pkg::DP_LOAD;
               idx_in   = '0;
               n_in     = '0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.command)
               sstq_pkg::CMD_ADD: begin
                  if (stat.count != sstq_pkg::IDX_W'(sstq_pkg::QUEUE_DEPTH)) begin
                     state_in = S_ADD_SCAN;
                  end else if (stat.out_free) begin
                     ctl.res_load   = 1'b1;
                     ctl.res_status = sstq_pkg::ST_FULL;
                     state_in       = S_IDLE;
                  end
               end
               sstq_pkg::CMD_REMOVE: begin
                  state_in = S_REM_SCAN;
               end
               sstq_pkg::CMD_TICK: begin
                  state_in = S_AGE;
               end
               default: begin
                  if (stat.out_free) begin
                     ctl.res_load = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         S_ADD_SCAN: begin
            if (idx_ff < stat.count && stat.rem_lt) begin
               idx_in = idx_ff + 1'b1;
            end else if (stat.out_free) begin
               ctl.op       = sstq_pkg::DP_INSERT;
               ctl.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_REM_SCAN: begin
            if (idx_ff == stat.count) begin
               if (stat.out_free) begin
                  ctl.res_load   = 1'b1;
                  ctl.res_status = sstq_pkg::ST_NOTFOUND;
                  state_in       = S_IDLE;
               end
            end else if (stat.task_match) begin
               if (stat.out_free) begin
                  ctl.op       = sstq_pkg::DP_DROP;
                  ctl.res_load = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_AGE: begin
            if (idx_ff < stat.count) begin
               ctl.op = sstq_pkg::DP_AGE;
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in   = '0;
               state_in = S_POP;
            end
         end
         S_POP: begin
            ctl.idx = '0;
            if (stat.out_free) begin
               ctl.res_load = 1'b1;
               if (stat.count != '0 && stat.head_zero) begin
                  ctl.op         = sstq_pkg::DP_DROP;
                  ctl.res_status = sstq_pkg::ST_WOKEN;
                  ctl.res_last   = !more;
                  n_in           = n_ff + 1'b1;
                  if (!more) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
      end
   end

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.op == sstq_pkg::DP_INSERT
      |-> stat.count < sstq_pkg::IDX_W'(sstq_pkg::QUEUE_DEPTH))
      else $error("insert issued into a full queue");

   a_drop_not_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.op == sstq_pkg::DP_DROP |-> stat.count != '0)
      else $error("drop issued on an empty queue");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.res_load |-> stat.out_free)
      else $error("result loaded over an item not yet taken");

   a_wake_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= sstq_pkg::NRES_W'(sstq_pkg::MAX_RESULTS))
      else $error("too many wakes in one tick");

endmodule

`default_nettype wire

// ===== design/sorted_sleep_timer_queue.sv =====
// Top level of the sorted sleep timer queue: controller, datapath and channel wiring.
// An item is taken only in idle and decoded in dispatch; a scan then visits one entry a cycle.
// Add scans to its insert position and remove to its match position; tick ages every entry,
// then pops one woken task a cycle. A stalled result register holds the sequencer.
// Synchronous reset empties the queue and the result register; entry contents stay undefined.
`default_nettype none

module sorted_sleep_timer_queue (
   input  wire logic  clock,
   input  wire logic  reset,
   sstq_req_if.sink   req_chan,
   sstq_rsp_if.source rsp_chan
);

   sstq_pkg::req_item_type  req_item;
   sstq_pkg::ctrl_cmd_type  ctl;
   sstq_pkg::dp_status_type stat;
   logic                    req_ready;

   always_comb begin
      req_item.command     = req_chan.command;
      req_item.task_id     = req_chan.task_id;
      req_item.sleep_ticks = req_chan.sleep_ticks;
      req_item.now_time    = req_chan.now_time;
   end

   assign req_chan.ready = req_ready;

   sstq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   sstq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_item        (req_item),
      .ctl             (ctl),
      .stat            (stat),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_woken_task  (rsp_chan.woken_task),
      .rsp_last_result (rsp_chan.last_result)
   );

endmodule

`default_nettype wire

// ===== test/sorted_sleep_timer_queue_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the sorted sleep timer queue: directed and random commands checked against a model.
module sorted_sleep_timer_queue_tb;
   import sstq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 30;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TASK_W-1:0]   woken_task;
      logic                last_result;
   } timer_result_type;

   class sleep_queue_scoreboard;
      logic [TASK_W-1:0]  sleeper_task  [QUEUE_DEPTH];
      logic [TICKS_W-1:0] sleeper_ticks [QUEUE_DEPTH];
      logic [TIME_W-1:0]  sleeper_stamp [QUEUE_DEPTH];
      int                 sleepers;
      timer_result_type   expected_results [$];
      int                 errors;

      function new();
         sleepers = 0;
         errors = 0;
      endfunction

      function void drop_sleeper(int pos);
         for (int i = pos; i + 1 < sleepers; i++) begin
            sleeper_task[i]  = sleeper_task[i + 1];
            sleeper_ticks[i] = sleeper_ticks[i + 1];
            sleeper_stamp[i] = sleeper_stamp[i + 1];
         end
         sleepers--;
      endfunction

      function void push_result(logic [STATUS_W-1:0] status, logic [TASK_W-1:0] tid,
                                logic last);
         timer_result_type r;
         r.status = status;
         r.woken_task = tid;
         r.last_result = last;
         expected_results.push_back(r);
      endfunction

      function void note_request(req_item_type item);
         int                pos;
         int                woken;
         logic [TIME_W-1:0] elapsed;
         logic [TASK_W-1:0] held_task;
         case (item.command)
            CMD_ADD: begin
               if (sleepers >= QUEUE_DEPTH) begin
                  push_result(ST_FULL, '0, 1'b1);
               end else begin
                  pos = 0;
                  while (pos < sleepers && sleeper_ticks[pos] < item.sleep_ticks)
                     pos++;
                  for (int i = sleepers; i > pos; i--) begin
                     sleeper_task[i]  = sleeper_task[i - 1];
                     sleeper_ticks[i] = sleeper_ticks[i - 1];
                     sleeper_stamp[i] = sleeper_stamp[i - 1];
                  end
                  sleeper_task[pos]  = item.task_id;
                  sleeper_ticks[pos] = item.sleep_ticks;
                  sleeper_stamp[pos] = item.now_time;
                  sleepers++;
                  push_result(ST_DONE, '0, 1'b1);
               end
            end
            CMD_REMOVE: begin
               pos = 0;
               while (pos < sleepers && sleeper_task[pos] != item.task_id)
                  pos++;
               if (pos < sleepers) begin
                  drop_sleeper(pos);
                  push_result(ST_DONE, '0, 1'b1);
               end else begin
                  push_result(ST_NOTFOUND, '0, 1'b1);
               end
            end
            CMD_TICK: begin
               for (int i = 0; i < sleepers; i++) begin
                  elapsed = item.now_time - sleeper_stamp[i];
                  if (elapsed >= {{(TIME_W - TICKS_W){1'b0}}, sleeper_ticks[i]})
                     sleeper_ticks[i] = '0;
                  else
                     sleeper_ticks[i] = sleeper_ticks[i] - elapsed[TICKS_W-1:0];
                  sleeper_stamp[i] = item.now_time;
               end
               woken = 0;
               held_task = '0;
               while (woken < MAX_RESULTS && sleepers > 0 && sleeper_ticks[0] == '0) begin
                  if (woken > 0)
                     push_result(ST_WOKEN, held_task, 1'b0);
                  held_task = sleeper_task[0];
                  drop_sleeper(0);
                  woken++;
               end
               if (woken == 0)
                  push_result(ST_DONE, '0, 1'b1);
               else
                  push_result(ST_WOKEN, held_task, 1'b1);
            end
            default: begin
               push_result(ST_DONE, '0, 1'b1);
            end
         endcase
      endfunction

      function void check_result(timer_result_type got);
         timer_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: expected none, actual status %0d task %0d last %0d",
                     $time, got.status, got.woken_task, got.last_result);
         end else begin
            want = expected_results.pop_front();
            if (got.status != want.status) begin
               errors++;
               $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            end
            if (got.woken_task != want.woken_task) begin
               errors++;
               $display("%0t: woken_task expected %0d, actual %0d", $time, want.woken_task,
                        got.woken_task);
            end
            if (got.last_result != want.last_result) begin
               errors++;
               $display("%0t: last_result expected %0d, actual %0d", $time, want.last_result,
                        got.last_result);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                hold_asks;
   int                items_sent;
   logic [TIME_W-1:0] ms_now;

   sleep_queue_scoreboard queue_model = new();

   sstq_req_if req_chan ();
   sstq_rsp_if rsp_chan ();

   sorted_sleep_timer_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : receiver
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            queue_model.check_result('{rsp_chan.status, rsp_chan.woken_task,
                                       rsp_chan.last_result});
         if (hold_asks != holds_seen) begin
            holds_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (reset || hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            if (hold_left > 0)
               hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TASK_W-1:0] id,
                            input logic [TICKS_W-1:0] ticks, input logic [TIME_W-1:0] now);
      req_item_type item;
      item = '{cmd, id, ticks, now};
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.task_id     <= id;
      req_chan.sleep_ticks <= ticks;
      req_chan.now_time    <= now;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      queue_model.note_request(item);
      items_sent++;
   endtask

   task automatic run_random(input int target);
      int                 stop_at;
      int                 pick;
      logic [TASK_W-1:0]  id;
      logic [TICKS_W-1:0] ticks;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         id = TASK_W'($urandom_range(0, 7));
         if (pick < 45) begin
            if ($urandom_range(0, 9) == 0)
               ticks = TICKS_W'($urandom());
            else
               ticks = TICKS_W'($urandom_range(1, 60));
            ms_now += $urandom_range(0, 15);
            send_item(CMD_ADD, id, ticks, ms_now);
         end else if (pick < 60) begin
            if (queue_model.sleepers > 0 && $urandom_range(0, 9) < 7)
               id = queue_model.sleeper_task[$urandom_range(0, queue_model.sleepers - 1)];
            send_item(CMD_REMOVE, id, TICKS_W'($urandom()), ms_now);
         end else if (pick < 88) begin
            ms_now += $urandom_range(0, 40);
            send_item(CMD_TICK, id, TICKS_W'($urandom()), ms_now);
         end else if (pick < 94) begin
            while (queue_model.sleepers < QUEUE_DEPTH)
               send_item(CMD_ADD, TASK_W'($urandom()), TICKS_W'($urandom_range(1, 30)), ms_now);
            send_item(CMD_ADD, id, TICKS_W'($urandom_range(1, 30)), ms_now);
            ms_now += $urandom_range(30, 100);
            send_item(CMD_TICK, id, TICKS_W'($urandom()), ms_now);
         end else if (pick < 97) begin
            send_item(CMD_NOP, id, TICKS_W'($urandom()), TIME_W'($urandom()));
         end else begin
            ms_now = TIME_W'($urandom());
            send_item(CMD_TICK, id, TICKS_W'($urandom()), ms_now);
         end
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.command     <= CMD_ADD;
      req_chan.task_id     <= '0;
      req_chan.sleep_ticks <= '0;
      req_chan.now_time    <= '0;
      recv_idle_pct        <= 69;
      hold_asks            <= 0;
      send_idle_pct = 34;
      items_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_TICK, 3'd0, 16'd0, 32'd0);
      send_item(CMD_REMOVE, 3'd5, 16'd0, 32'd0);
      send_item(CMD_NOP, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
      ms_now = 32'hFFFF_FFF0;
      send_item(CMD_ADD, 3'd0, 16'hFFFF, ms_now);
      send_item(CMD_ADD, 3'd7, 16'd1, ms_now);
      send_item(CMD_ADD, 3'd3, 16'd0, ms_now);
      send_item(CMD_ADD, 3'd3, 16'd100, ms_now);
      send_item(CMD_ADD, 3'd5, 16'd100, ms_now);
      send_item(CMD_ADD, 3'd2, 16'd50, ms_now);
      send_item(CMD_ADD, 3'd6, 16'h8000, ms_now);
      send_item(CMD_ADD, 3'd1, 16'd20, ms_now);
      send_item(CMD_ADD, 3'd4, 16'd10, ms_now);
      send_item(CMD_REMOVE, 3'd3, 16'd0, ms_now);
      send_item(CMD_ADD, 3'd4, 16'd10, ms_now);
      send_item(CMD_TICK, 3'd0, 16'd0, 32'h0000_0010);
      send_item(CMD_TICK, 3'd0, 16'd0, 32'h0000_000F);
      // A later, shorter sleeper goes ahead of an older one, which then reaches zero behind it.
      send_item(CMD_ADD, 3'd1, 16'd100, 32'd0);
      send_item(CMD_ADD, 3'd2, 16'd50, 32'd90);
      send_item(CMD_TICK, 3'd0, 16'd0, 32'd100);
      send_item(CMD_REMOVE, 3'd2, 16'd0, 32'd100);
      send_item(CMD_TICK, 3'd0, 16'd0, 32'd100);
      ms_now = 32'd200;

      run_random(50);
      send_idle_pct = 69;
      recv_idle_pct <= 34;
      run_random(50);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_asks <= hold_asks + 1;
      run_random(50);
      req_chan.valid <= 1'b0;

      while (queue_model.expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (queue_model.errors == 0 && queue_model.expected_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
